[sv/atb_pkg.sv]
// Package for the alias table builder: payload types, state codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package atb_pkg;
    localparam int MaxEntries = 4096;
    localparam logic [63:0] OneFx = 64'h1_0000_0000;
    localparam logic [47:0] Mask48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [43:0] Mask44 = 44'hFFF_FFFF_FFFF;
    localparam logic [31:0] ProbMax = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] index;
        logic [31:0] weight;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] alias_index;
        logic [31:0] probability;
        logic [47:0] pdf;
        logic [47:0] alias_norm;
        logic [43:0] weight_sum;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE, S_RD1, S_RD2, S_OUT,
        S_SUM_RD, S_SUM_ACC, S_INIT,
        S_NRM_RD, S_NRM_MUL, S_NRM_DIV, S_NRM_WR,
        S_SI_RD, S_SI_CHK, S_SJ_RD, S_SJ_CHK,
        S_LOOP, S_LI_RD, S_LI_CHK, S_LJ_RD, S_LJ_CHK, S_LJ_CARRY
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [47:0] quo;
    } t_div_rsp;
endpackage

[sv/atb_ram.sv]
// Generic single-port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module atb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/atb_div.sv]
// Bit-serial divider for weight normalization: floor(num * 2^32 / den), saturated to 48 bits.
// Depends on atb_pkg.
`timescale 1ns / 1ps
module atb_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  atb_pkg::t_div_req i_req,
    output atb_pkg::t_div_rsp o_rsp
);
    logic [95:0] r_num;
    logic [64:0] r_rem;
    logic [63:0] r_den;
    logic [47:0] r_quo;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] n_rem;
    logic [64:0] n_sh;

    always_comb begin
        n_sh  = {r_rem[63:0], r_num[95]};
        n_rem = n_sh;
        if (n_sh >= {1'b0, r_den}) begin
            n_rem = n_sh - {1'b0, r_den};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == 7'd1);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd96;
                r_num  <= {i_req.num, 32'd0};
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[94:0], 1'b0};
                r_rem <= n_rem;
                if (r_quo[47]) begin
                    r_quo <= atb_pkg::Mask48;
                end else begin
                    r_quo <= {r_quo[46:0], n_sh >= {1'b0, r_den}};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

[sv/alias_table_builder.sv]
// Top level of the alias table builder: command sequencer over four weight/table RAMs.
// Depends on atb_pkg, atb_ram, atb_div.
// Load, no-op and out-of-range items: result valid 2 cycles after accept, 4 cycles per item.
// Read: result valid 3 cycles after accept, 5 cycles per item (own entry, then its alias).
// Build: 2N+1 to sum, N to init, 101 per entry through the serial divider, up to about 7N
// to sweep. A held result stalls input. Sync active-low reset clears control, count = 4096.
`timescale 1ns / 1ps
module alias_table_builder #(
    parameter int MAX_ENTRIES = atb_pkg::MaxEntries
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [12:0]   i_cfg_data,
    input  logic          i_valid,
    output logic          o_stall,
    input  atb_pkg::t_in  i_item,
    output logic          o_valid,
    input  logic          i_stall,
    output atb_pkg::t_out o_item
);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = AW + 1;

    atb_pkg::t_state r_state, n_state;
    logic [12:0] r_cfg;
    logic [CW-1:0] w_n;
    atb_pkg::t_in r_in;
    atb_pkg::t_out r_out;
    logic r_ov;
    logic [63:0] r_sum;
    logic [CW-1:0] r_k, r_i, r_j, r_prev;
    logic [63:0] r_carry, r_num;
    logic [47:0] r_tmp;
    logic r_in_sweep;

    logic [AW-1:0] w_addr;
    logic w_we_raw, w_we_nrm, w_we_al, w_we_pr;
    logic [47:0] w_nrm_wd;
    logic [AW-1:0] w_al_wd;
    logic [31:0] w_pr_wd;
    logic [31:0] w_raw_rd, w_pr_rd;
    logic [47:0] w_nrm_rd;
    logic [AW-1:0] w_al_rd;
    atb_pkg::t_div_req w_dreq;
    atb_pkg::t_div_rsp w_drsp;

    always_comb begin
        if (r_cfg == 13'd0) begin
            w_n = CW'(1);
        end else if ({19'd0, r_cfg} > 32'(MAX_ENTRIES)) begin
            w_n = CW'(MAX_ENTRIES);
        end else begin
            w_n = CW'(r_cfg);
        end
    end

    atb_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_raw (
        .i_clk(i_clk), .i_we(w_we_raw), .i_addr(w_addr),
        .i_wdata(r_in.weight), .o_rdata(w_raw_rd));
    atb_ram #(.WIDTH(48), .DEPTH(MAX_ENTRIES)) u_nrm (
        .i_clk(i_clk), .i_we(w_we_nrm), .i_addr(w_addr),
        .i_wdata(w_nrm_wd), .o_rdata(w_nrm_rd));
    atb_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_al (
        .i_clk(i_clk), .i_we(w_we_al), .i_addr(w_we_al && r_state == atb_pkg::S_LJ_CARRY
                                                ? r_prev[AW-1:0] : w_addr),
        .i_wdata(w_al_wd), .o_rdata(w_al_rd));
    atb_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_pr (
        .i_clk(i_clk), .i_we(w_we_pr), .i_addr(w_addr),
        .i_wdata(w_pr_wd), .o_rdata(w_pr_rd));

    atb_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    function automatic logic [31:0] f_prob(input logic [63:0] v);
        f_prob = (v > 64'(atb_pkg::ProbMax)) ? atb_pkg::ProbMax : v[31:0];
    endfunction

    function automatic logic [63:0] f_step(input logic [63:0] c, input logic [47:0] w);
        logic [64:0] t;
        t = {1'b0, c} + {17'd0, w};
        f_step = (t >= {1'b0, atb_pkg::OneFx}) ? 64'(t - {1'b0, atb_pkg::OneFx}) : 64'd0;
    endfunction

    logic w_heavy;
    assign w_heavy = {16'd0, w_nrm_rd} > atb_pkg::OneFx;
    assign o_stall = (r_state != atb_pkg::S_IDLE) || r_ov;
    assign o_valid = r_ov;
    assign o_item  = r_out;
    assign w_nrm_wd = (r_state == atb_pkg::S_INIT) ? 48'(atb_pkg::OneFx) : w_drsp.quo;

    always_comb begin
        n_state  = r_state;
        w_addr   = AW'(r_in.index);
        w_we_raw = 1'b0;
        w_we_nrm = 1'b0;
        w_we_al  = 1'b0;
        w_we_pr  = 1'b0;
        w_al_wd  = r_k[AW-1:0];
        w_pr_wd  = atb_pkg::ProbMax;
        w_dreq   = '0;
        case (r_state)
            atb_pkg::S_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_state = atb_pkg::S_RD1;
                end
            end
            atb_pkg::S_RD1: begin
                if (r_in.cmd == atb_pkg::CMD_BUILD) begin
                    n_state = atb_pkg::S_SUM_RD;
                end else if (32'(r_in.index) >= 32'(w_n) ||
                             r_in.cmd == atb_pkg::CMD_NONE) begin
                    n_state = atb_pkg::S_OUT;
                end else if (r_in.cmd == atb_pkg::CMD_LOAD) begin
                    w_we_raw = 1'b1;
                    n_state  = atb_pkg::S_OUT;
                end else begin
                    n_state = atb_pkg::S_RD2;
                end
            end
            atb_pkg::S_RD2: begin
                w_addr  = w_al_rd;
                n_state = atb_pkg::S_OUT;
            end
            atb_pkg::S_OUT: n_state = atb_pkg::S_IDLE;
            atb_pkg::S_SUM_RD: begin
                w_addr = r_k[AW-1:0];
                n_state = (r_k == w_n) ? atb_pkg::S_INIT : atb_pkg::S_SUM_ACC;
            end
            atb_pkg::S_SUM_ACC: n_state = atb_pkg::S_SUM_RD;
            atb_pkg::S_INIT: begin
                w_addr  = r_k[AW-1:0];
                w_we_al = 1'b1;
                w_we_pr = 1'b1;
                w_we_nrm = (r_sum == 64'd0);
                if (r_k + CW'(1) == w_n) begin
                    n_state = (r_sum == 64'd0) ? atb_pkg::S_OUT : atb_pkg::S_NRM_RD;
                end
            end
            atb_pkg::S_NRM_RD: begin
                w_addr = r_k[AW-1:0];
                n_state = (r_k == w_n) ? atb_pkg::S_SI_RD : atb_pkg::S_NRM_MUL;
            end
            atb_pkg::S_NRM_MUL: n_state = atb_pkg::S_NRM_DIV;
            atb_pkg::S_NRM_DIV: begin
                if (!w_drsp.busy && !w_drsp.done) begin
                    w_dreq.start = 1'b1;
                    w_dreq.num   = r_num;
                    w_dreq.den   = r_sum;
                end
                if (w_drsp.done) begin
                    n_state = atb_pkg::S_NRM_WR;
                end
            end
            atb_pkg::S_NRM_WR: begin
                w_addr = r_k[AW-1:0];
                w_we_nrm = 1'b1;
                n_state = atb_pkg::S_NRM_RD;
            end
            atb_pkg::S_SI_RD: begin
                w_addr = r_i[AW-1:0];
                if (r_i >= w_n) begin
                    n_state = r_in_sweep ? atb_pkg::S_LOOP : atb_pkg::S_SJ_RD;
                end else begin
                    n_state = atb_pkg::S_SI_CHK;
                end
            end
            atb_pkg::S_SI_CHK: begin
                if (w_heavy) begin
                    n_state = atb_pkg::S_SI_RD;
                end else begin
                    n_state = r_in_sweep ? atb_pkg::S_LOOP : atb_pkg::S_SJ_RD;
                end
            end
            atb_pkg::S_SJ_RD: begin
                w_addr = r_j[AW-1:0];
                n_state = (r_j >= w_n) ? atb_pkg::S_OUT : atb_pkg::S_SJ_CHK;
            end
            atb_pkg::S_SJ_CHK: n_state = w_heavy ? atb_pkg::S_LOOP : atb_pkg::S_SJ_RD;
            atb_pkg::S_LOOP: begin
                if (r_j >= w_n) begin
                    n_state = atb_pkg::S_OUT;
                end else if (r_carry > atb_pkg::OneFx) begin
                    w_addr = r_i[AW-1:0];
                    n_state = (r_i >= w_n) ? atb_pkg::S_OUT : atb_pkg::S_LI_RD;
                end else begin
                    w_addr  = r_j[AW-1:0];
                    w_we_pr = 1'b1;
                    w_pr_wd = f_prob(r_carry);
                    n_state = atb_pkg::S_LJ_RD;
                end
            end
            atb_pkg::S_LI_RD: begin
                w_addr = r_i[AW-1:0];
                n_state = atb_pkg::S_LI_CHK;
            end
            atb_pkg::S_LI_CHK: begin
                w_addr  = r_i[AW-1:0];
                w_we_pr = 1'b1;
                w_pr_wd = f_prob({16'd0, w_nrm_rd});
                w_we_al = 1'b1;
                w_al_wd = r_j[AW-1:0];
                n_state = atb_pkg::S_SI_RD;
            end
            atb_pkg::S_LJ_RD: begin
                w_addr = r_j[AW-1:0];
                n_state = (r_j >= w_n) ? atb_pkg::S_OUT : atb_pkg::S_LJ_CHK;
            end
            atb_pkg::S_LJ_CHK: n_state = w_heavy ? atb_pkg::S_LJ_CARRY : atb_pkg::S_LJ_RD;
            atb_pkg::S_LJ_CARRY: begin
                w_we_al = 1'b1;
                w_al_wd = r_j[AW-1:0];
                n_state = atb_pkg::S_LOOP;
            end
            default: n_state = atb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= atb_pkg::S_IDLE;
            r_cfg   <= 13'd4096;
            r_ov    <= 1'b0;
            r_in_sweep <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                atb_pkg::S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_in  <= i_item;
                        r_out <= '0;
                        r_k   <= '0;
                        r_sum <= '0;
                    end
                end
                atb_pkg::S_RD1: begin
                    if (32'(r_in.index) >= 32'(w_n) && r_in.cmd != atb_pkg::CMD_BUILD
                        && r_in.cmd != atb_pkg::CMD_NONE) begin
                        r_out.status <= atb_pkg::ST_RANGE;
                    end
                end
                atb_pkg::S_RD2: begin
                    r_out.alias_index <= 12'(w_al_rd);
                    r_out.probability <= w_pr_rd;
                    r_out.pdf <= w_nrm_rd;
                end
                atb_pkg::S_OUT: begin
                    if (r_in.cmd == atb_pkg::CMD_READ && r_out.status == atb_pkg::ST_OK) begin
                        r_out.alias_norm <= w_nrm_rd;
                    end
                    r_ov <= 1'b1;
                end
                atb_pkg::S_SUM_RD: begin
                    if (r_k == w_n) begin
                        r_k <= '0;
                        r_out.weight_sum <= (r_sum > 64'(atb_pkg::Mask44)) ? atb_pkg::Mask44
                                                                          : r_sum[43:0];
                    end
                end
                atb_pkg::S_SUM_ACC: begin
                    r_sum <= r_sum + {32'd0, w_raw_rd};
                    r_k   <= r_k + CW'(1);
                end
                atb_pkg::S_INIT: begin
                    if (r_k + CW'(1) == w_n) begin
                        r_k <= '0;
                        if (r_sum == 64'd0) r_out.status <= atb_pkg::ST_ZERO;
                    end else begin
                        r_k <= r_k + CW'(1);
                    end
                end
                atb_pkg::S_NRM_RD: begin
                    if (r_k == w_n) begin
                        r_i <= '0;
                        r_j <= '0;
                        r_in_sweep <= 1'b0;
                    end
                end
                atb_pkg::S_NRM_MUL: r_num <= 64'(w_raw_rd) * 64'(w_n);
                atb_pkg::S_NRM_WR: r_k <= r_k + CW'(1);
                atb_pkg::S_SI_CHK: if (w_heavy) r_i <= r_i + CW'(1);
                atb_pkg::S_SJ_CHK: begin
                    if (w_heavy) begin
                        r_carry <= {16'd0, w_nrm_rd};
                        r_in_sweep <= 1'b1;
                    end else begin
                        r_j <= r_j + CW'(1);
                    end
                end
                atb_pkg::S_LOOP: begin
                    if (r_j < w_n && r_carry <= atb_pkg::OneFx) begin
                        r_prev <= r_j;
                        r_j    <= r_j + CW'(1);
                    end
                end
                atb_pkg::S_LI_CHK: begin
                    r_carry <= f_step(r_carry, w_nrm_rd);
                    r_i <= r_i + CW'(1);
                end
                atb_pkg::S_LJ_CHK: begin
                    if (w_heavy) r_tmp <= w_nrm_rd;
                    else r_j <= r_j + CW'(1);
                end
                atb_pkg::S_LJ_CARRY: r_carry <= f_step(r_carry, r_tmp);
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != atb_pkg::S_IDLE) |-> o_stall)
        else $error("item taken while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we_raw && w_we_nrm) == 1'b0)
        else $error("load overlaps build write");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == atb_pkg::S_OUT) |=> r_ov)
        else $error("result lost");
endmodule

[verif/alias_table_builder_checker.sv]
// Checker for the alias table builder: watches the config port and both item channels,
// predicts every result from its own copy of the weights and table, and counts mismatches.
// Depends on atb_pkg.
`timescale 1ns / 1ps
module alias_table_builder_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [12:0]   i_cfg_data,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  atb_pkg::t_in  i_in_item,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  atb_pkg::t_out i_out_item,
    output int            o_fail_count,
    output int            o_pending
);
    import atb_pkg::*;

    logic [31:0] raw_w     [MaxEntries];
    logic [47:0] nrm_w     [MaxEntries];
    logic [11:0] alias_tab [MaxEntries];
    logic [31:0] keep_prob [MaxEntries];
    logic [43:0] sum_q1616;
    logic [12:0] entry_cnt;
    t_out        expected_items[$];

    function automatic int used_count();
        int c;
        c = entry_cnt;
        if (c == 0) c = 1;
        if (c > MaxEntries) c = MaxEntries;
        return c;
    endfunction

    function automatic logic [47:0] norm_weight(logic [31:0] w, int n, logic [63:0] s);
        logic [127:0] q;
        q = ({96'd0, w} * n << 32) / {64'd0, s};
        return (q > {80'd0, Mask48}) ? Mask48 : q[47:0];
    endfunction

    function automatic logic [31:0] sat_prob(logic [63:0] v);
        return (v > {32'd0, ProbMax}) ? ProbMax : v[31:0];
    endfunction

    function automatic logic [63:0] next_carry(logic [63:0] c, logic [47:0] w);
        logic [63:0] t;
        t = c + w;
        return (t >= OneFx) ? t - OneFx : 64'd0;
    endfunction

    function automatic logic [1:0] build_table(int n);
        logic [63:0] s;
        logic [63:0] carry;
        int i, j, prev;
        s = 0;
        for (int k = 0; k < n; k++) s += raw_w[k];
        sum_q1616 = (s > {20'd0, Mask44}) ? Mask44 : s[43:0];
        for (int k = 0; k < n; k++) begin
            alias_tab[k] = k[11:0];
            keep_prob[k] = ProbMax;
        end
        if (s == 0) begin
            for (int k = 0; k < n; k++) nrm_w[k] = OneFx[47:0];
            return ST_ZERO;
        end
        for (int k = 0; k < n; k++) nrm_w[k] = norm_weight(raw_w[k], n, s);
        i = 0;
        j = 0;
        while (i < n && nrm_w[i] > OneFx) i++;
        while (j < n && nrm_w[j] <= OneFx) j++;
        carry = (j < n) ? {16'd0, nrm_w[j]} : 64'd0;
        while (j < n) begin
            if (carry > OneFx) begin
                if (i >= n) break;
                keep_prob[i] = sat_prob({16'd0, nrm_w[i]});
                alias_tab[i] = j[11:0];
                carry = next_carry(carry, nrm_w[i]);
                i++;
                while (i < n && nrm_w[i] > OneFx) i++;
            end else begin
                prev = j;
                keep_prob[j] = sat_prob(carry);
                j++;
                while (j < n && nrm_w[j] <= OneFx) j++;
                if (j < n) begin
                    alias_tab[prev] = j[11:0];
                    carry = next_carry(carry, nrm_w[j]);
                end
            end
        end
        return ST_OK;
    endfunction

    function automatic t_out predict_item(t_in it);
        t_out r;
        int n;
        logic [11:0] a;
        r = '0;
        n = used_count();
        case (it.cmd)
            CMD_LOAD: begin
                if (it.index >= n) r.status = ST_RANGE;
                else raw_w[it.index] = it.weight;
            end
            CMD_BUILD: begin
                r.status = build_table(n);
                r.weight_sum = sum_q1616;
            end
            CMD_READ: begin
                if (it.index >= n) begin
                    r.status = ST_RANGE;
                end else begin
                    a = alias_tab[it.index];
                    r.alias_index = a;
                    r.probability = keep_prob[it.index];
                    r.pdf = nrm_w[it.index];
                    r.alias_norm = nrm_w[a];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    assign o_pending = expected_items.size();

    always @(posedge i_clk) begin
        t_out exp_item;
        if (!i_rst_n) begin
            entry_cnt <= 13'd4096;
            sum_q1616 = '0;
            expected_items.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) entry_cnt <= i_cfg_data;
            if (i_in_valid && !i_in_stall) expected_items.push_back(predict_item(i_in_item));
            if (i_out_valid && !i_out_stall) begin
                if (expected_items.size() == 0) begin
                    $display("%0t: unexpected item %h", $time, i_out_item);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_item = expected_items.pop_front();
                    if (exp_item.status !== i_out_item.status ||
                        exp_item.alias_index !== i_out_item.alias_index ||
                        exp_item.probability !== i_out_item.probability ||
                        exp_item.pdf !== i_out_item.pdf ||
                        exp_item.alias_norm !== i_out_item.alias_norm ||
                        exp_item.weight_sum !== i_out_item.weight_sum) begin
                        $display("%0t: mismatch expected st=%0d al=%0d pr=%h pdf=%h apdf=%h sum=%h",
                                 $time, exp_item.status, exp_item.alias_index,
                                 exp_item.probability, exp_item.pdf, exp_item.alias_norm,
                                 exp_item.weight_sum);
                        $display("%0t:          actual   st=%0d al=%0d pr=%h pdf=%h apdf=%h sum=%h",
                                 $time, i_out_item.status, i_out_item.alias_index,
                                 i_out_item.probability, i_out_item.pdf, i_out_item.alias_norm,
                                 i_out_item.weight_sum);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[verif/alias_table_builder_tb.sv]
// Testbench top for the alias table builder: clock, reset, config writes and item stimulus
// over several entry counts and idle patterns. Depends on atb_pkg, the block and its checker.
`timescale 1ns / 1ps
module alias_table_builder_tb;
    import atb_pkg::*;

    localparam int CycleLimit = 4000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [12:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    t_in         i_item;
    logic        o_valid;
    logic        i_stall;
    t_out        o_item;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          stall_pct;
    int          cycle_cnt;
    int          built_n;

    alias_table_builder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

    alias_table_builder_checker checker_0 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_item    (i_item),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_item   (o_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleLimit) begin
            $display("alias_table_builder regression: fail");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] cmd, int idx, logic [31:0] w);
        t_in it;
        it.cmd = cmd;
        it.index = idx[11:0];
        it.weight = w;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain_and_write(logic [12:0] cnt);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= cnt;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(255);
            3: return 32'h0001_0000 + $urandom_range(4095);
            default: return $urandom;
        endcase
    endfunction

    task automatic load_all(int n);
        for (int k = 0; k < n; k++) send_item(CMD_LOAD, k, rand_weight());
    endtask

    task automatic build_now(int n);
        send_item(CMD_BUILD, $urandom_range(4095), $urandom);
        built_n = n;
    endtask

    task automatic random_items(int n, int count, bit allow_build);
        int roll;
        int lim;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            lim = (built_n < n) ? built_n : n;
            if (roll < 40) begin
                send_item(CMD_LOAD, ($urandom_range(9) == 0) ? $urandom_range(4095)
                          : $urandom_range(n - 1), rand_weight());
            end else if (roll < 85) begin
                send_item(CMD_READ, ($urandom_range(9) == 0) ? $urandom_range(n, 4095 + (n == 4096))
                          : $urandom_range(lim - 1), $urandom);
            end else if (roll < 93 && allow_build) begin
                build_now(n);
            end else begin
                send_item(CMD_NONE, $urandom_range(4095), $urandom);
            end
        end
    endtask

    initial begin
        int counts[7] = '{0, 5, 2, 16, 64, 300, 8191};
        int n;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_item = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        built_n = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < 7; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 50; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 50; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            drain_and_write(counts[p][12:0]);
            n = (counts[p] == 0) ? 1 : (counts[p] > 4096 ? 4096 : counts[p]);
            if (n == 5) begin
                for (int k = 0; k < 5; k++) send_item(CMD_LOAD, k, 32'd0);
                build_now(n);
                send_item(CMD_READ, 0, 32'd0);
                send_item(CMD_READ, 4, 32'd0);
                send_item(CMD_READ, 4095, 32'd0);
                send_item(CMD_LOAD, 4095, 32'hFFFF_FFFF);
                send_item(CMD_NONE, 4095, 32'hFFFF_FFFF);
                send_item(CMD_LOAD, 0, 32'hFFFF_FFFF);
                send_item(CMD_LOAD, 1, 32'd1);
                send_item(CMD_LOAD, 3, 32'h8000_0000);
                send_item(CMD_LOAD, 4, 32'h0001_0000);
                build_now(n);
                for (int k = 0; k < 5; k++) send_item(CMD_READ, k, 32'd0);
            end else if (n < 4096) begin
                load_all(n);
                build_now(n);
                send_item(CMD_READ, n - 1, 32'd0);
                send_item(CMD_READ, 0, 32'd0);
            end
            random_items(n, (n == 4096) ? 120 : 110, n <= 300);
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("alias_table_builder regression: pass");
        end else begin
            $display("alias_table_builder regression: fail");
        end
        $finish;
    end
endmodule

[files.f]
sv/atb_pkg.sv
sv/atb_ram.sv
sv/atb_div.sv
sv/alias_table_builder.sv
verif/alias_table_builder_checker.sv
verif/alias_table_builder_tb.sv
